@@ sv/wsd_pkg.sv @@
// Shared types and constants of the windowed squared-difference core.
package wsd_pkg;

  localparam int unsigned WLEN_W  = 10;
  localparam int unsigned SKIP_W  = 20;
  localparam int unsigned SBITS_W = 5;
  localparam int unsigned DIFF_W  = 31;
  localparam int unsigned LAG_W   = 20;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned CFG_DW  = 32;
  localparam int unsigned CFG_AW  = 4;

  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [1:0] REG_SKIP_COUNT    = 2'd1;
  localparam logic [1:0] REG_SAMPLE_BITS   = 2'd2;

  localparam logic [WLEN_W-1:0]  WLEN_RST  = 10'd400;
  localparam logic [SKIP_W-1:0]  SKIP_RST  = 20'd1500;
  localparam logic [SBITS_W-1:0] SBITS_RST = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_e;

  typedef struct packed {
    logic clear;
    logic pair_valid;
  } acc_ctrl_t;

  typedef struct packed {
    logic              busy;
    logic [DIFF_W-1:0] difference;
  } acc_stat_t;

endpackage

@@ sv/wsd_sq_acc.sv @@
// Squared-difference pipeline with saturating accumulator and output scaling.
module wsd_sq_acc #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  wsd_pkg::acc_ctrl_t                   ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       win_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       ref_i,
  input  logic        [wsd_pkg::SBITS_W-1:0]   shift_i,
  output wsd_pkg::acc_stat_t                   stat_o
);

  logic signed [SAMPLE_WIDTH:0]        diff;
  logic        [SAMPLE_WIDTH:0]        mag;
  logic        [32:0]                  mag_ext;
  logic        [31:0]                  mag_q;
  logic                                mag_ovf_q;
  logic                                va_q;
  logic        [wsd_pkg::SUM_W-1:0]    sq_c;
  logic        [wsd_pkg::SUM_W-1:0]    sq_q;
  logic                                vb_q;
  logic        [wsd_pkg::SUM_W:0]      sum_c;
  logic        [wsd_pkg::SUM_W-1:0]    acc_q;
  logic        [wsd_pkg::SUM_W-1:0]    acc_d;
  logic        [wsd_pkg::SUM_W-1:0]    shifted;

  assign diff = (SAMPLE_WIDTH + 1)'(win_i) - (SAMPLE_WIDTH + 1)'(ref_i);
  assign mag  = diff[SAMPLE_WIDTH] ? (SAMPLE_WIDTH + 1)'(-diff) : (SAMPLE_WIDTH + 1)'(diff);
  assign mag_ext = 33'(mag);
  assign sq_c = mag_ovf_q ? '1 : mag_q * mag_q;
  assign sum_c = {1'b0, acc_q} + {1'b0, sq_q};

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (vb_q) begin
      acc_d = sum_c[wsd_pkg::SUM_W] ? '1 : sum_c[wsd_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= ctrl_i.pair_valid;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_ext[31:0];
    mag_ovf_q <= mag_ext[32];
    sq_q      <= sq_c;
    acc_q     <= acc_d;
  end

  assign shifted = acc_q >> shift_i;
  assign stat_o.busy = va_q | vb_q;
  assign stat_o.difference = (|shifted[wsd_pkg::SUM_W-1:wsd_pkg::DIFF_W]) ?
                             '1 : shifted[wsd_pkg::DIFF_W-1:0];

endmodule

@@ sv/windowed_squared_difference_core.sv @@
// Top level: windowed squared-difference core with sample stores and APB registers.
// Each transfer is accepted only in the idle state; an item that yields a result holds the input
// off until its result is loaded, while one ring entry and one reference entry are read per cycle.
// The dual read of the two sample memories sets the rate: one product per cycle.
// The result register is loaded in the wait state once the read and accumulate stages are empty.
// Reset clears counters and handshakes and sets config registers to defaults; sample stores are not cleared.
module windowed_squared_difference_core #(
  parameter int unsigned MAX_WINDOW   = 512,
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_i,
  input  logic                                end_of_stream_i,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [wsd_pkg::DIFF_W-1:0]          difference_o,
  output logic [wsd_pkg::LAG_W-1:0]           lag_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wsd_pkg::CFG_AW-1:0]          paddr,
  input  logic [wsd_pkg::CFG_DW-1:0]          pwdata,
  output logic [wsd_pkg::CFG_DW-1:0]          prdata,
  output logic                                pready
);

  localparam int unsigned PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned WCNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IDX_W  = WCNT_W + 1;
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(MAX_WINDOW - 1);
  localparam logic [WCNT_W-1:0] WIN_MAX  = WCNT_W'(MAX_WINDOW);
  localparam logic [IDX_W-1:0]  IDX_MAX  = IDX_W'(MAX_WINDOW);

  logic [wsd_pkg::WLEN_W-1:0]  window_length_q;
  logic [wsd_pkg::SKIP_W-1:0]  skip_count_q;
  logic [wsd_pkg::SBITS_W-1:0] sample_bits_q;
  logic                        cfg_wr;

  wsd_pkg::state_e             state_q, state_d;
  logic [wsd_pkg::SKIP_W-1:0]  skipped_q, skipped_d, skipped_c;
  logic [WCNT_W-1:0]           fill_q, fill_d, fill_c;
  logic [PTR_W-1:0]            rp_q, rp_d, rp_c;
  logic [wsd_pkg::LAG_W-1:0]   lag_q, lag_d, lag_c;
  logic [wsd_pkg::LAG_W-1:0]   lag_pend_q, lag_pend_d;
  logic [PTR_W-1:0]            rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]            j_q, j_d;
  logic                        rd_valid_q;
  logic                        out_valid_q, out_valid_d;
  logic [wsd_pkg::DIFF_W-1:0]  diff_q, diff_d;
  logic [wsd_pkg::LAG_W-1:0]   lag_out_q, lag_out_d;

  logic [WCNT_W-1:0]           w_eff;
  logic                        in_fire;
  logic                        ring_we, ref_we;
  logic [PTR_W-1:0]            ref_wa;
  logic [IDX_W-1:0]            start_tmp;
  logic                        acc_clear;

  logic signed [SAMPLE_WIDTH-1:0] ring_mem [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] ref_mem  [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] ring_rd_q;
  logic signed [SAMPLE_WIDTH-1:0] ref_rd_q;

  wsd_pkg::acc_ctrl_t acc_ctrl;
  wsd_pkg::acc_stat_t acc_stat;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= wsd_pkg::WLEN_RST;
      skip_count_q    <= wsd_pkg::SKIP_RST;
      sample_bits_q   <= wsd_pkg::SBITS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        wsd_pkg::REG_WINDOW_LENGTH: window_length_q <= pwdata[wsd_pkg::WLEN_W-1:0];
        wsd_pkg::REG_SKIP_COUNT:    skip_count_q    <= pwdata[wsd_pkg::SKIP_W-1:0];
        wsd_pkg::REG_SAMPLE_BITS:   sample_bits_q   <= pwdata[wsd_pkg::SBITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      wsd_pkg::REG_WINDOW_LENGTH: prdata = wsd_pkg::CFG_DW'(window_length_q);
      wsd_pkg::REG_SKIP_COUNT:    prdata = wsd_pkg::CFG_DW'(skip_count_q);
      wsd_pkg::REG_SAMPLE_BITS:   prdata = wsd_pkg::CFG_DW'(sample_bits_q);
      default:                    prdata = '0;
    endcase
  end

  // clamp window length to 1..MAX_WINDOW
  always_comb begin
    if (window_length_q == '0) begin
      w_eff = WCNT_W'(1);
    end else if (32'(window_length_q) > 32'(MAX_WINDOW)) begin
      w_eff = WIN_MAX;
    end else begin
      w_eff = WCNT_W'(window_length_q);
    end
  end

  assign in_ready_o = (state_q == wsd_pkg::ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;

  assign skipped_c = restart_i ? '0 : skipped_q;
  assign fill_c    = restart_i ? '0 : fill_q;
  assign rp_c      = restart_i ? '0 : rp_q;
  assign lag_c     = restart_i ? '0 : lag_q;
  assign ref_wa    = PTR_W'(fill_c);

  always_comb begin
    state_d     = state_q;
    skipped_d   = skipped_q;
    fill_d      = fill_q;
    rp_d        = rp_q;
    lag_d       = lag_q;
    lag_pend_d  = lag_pend_q;
    rd_ptr_d    = rd_ptr_q;
    j_d         = j_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    diff_d      = diff_q;
    lag_out_d   = lag_out_q;
    ring_we     = 1'b0;
    ref_we      = 1'b0;
    acc_clear   = 1'b0;
    start_tmp   = '0;
    case (state_q)
      wsd_pkg::ST_IDLE: begin
        if (in_fire) begin
          skipped_d = skipped_c;
          fill_d    = fill_c;
          rp_d      = rp_c;
          lag_d     = lag_c;
          if (skipped_c < skip_count_q) begin
            skipped_d = skipped_c + 1'b1;
          end else begin
            ring_we = 1'b1;
            rp_d    = (rp_c == PTR_LAST) ? '0 : rp_c + 1'b1;
            if (fill_c < w_eff) begin
              ref_we = 1'b1;
              fill_d = fill_c + 1'b1;
            end
            if (!(fill_d < w_eff) && !end_of_stream_i) begin
              // window ends at the new ring pointer; start it w_eff entries back
              start_tmp  = IDX_W'(rp_d) + IDX_MAX - IDX_W'(w_eff);
              rd_ptr_d   = (start_tmp >= IDX_MAX) ? PTR_W'(start_tmp - IDX_MAX)
                                                  : PTR_W'(start_tmp);
              j_d        = '0;
              lag_pend_d = lag_c;
              lag_d      = lag_c + 1'b1;
              acc_clear  = 1'b1;
              state_d    = wsd_pkg::ST_RUN;
            end
          end
        end
      end
      wsd_pkg::ST_RUN: begin
        rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
        j_d      = j_q + 1'b1;
        if (WCNT_W'(j_q) == w_eff - 1'b1) begin
          state_d = wsd_pkg::ST_WAIT;
        end
      end
      wsd_pkg::ST_WAIT: begin
        if (!rd_valid_q && !acc_stat.busy && (!out_valid_q || out_ready_i)) begin
          out_valid_d = 1'b1;
          diff_d      = acc_stat.difference;
          lag_out_d   = lag_pend_q;
          state_d     = wsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wsd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wsd_pkg::ST_IDLE;
      skipped_q   <= '0;
      fill_q      <= '0;
      rp_q        <= '0;
      lag_q       <= '0;
      rd_ptr_q    <= '0;
      j_q         <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      skipped_q   <= skipped_d;
      fill_q      <= fill_d;
      rp_q        <= rp_d;
      lag_q       <= lag_d;
      rd_ptr_q    <= rd_ptr_d;
      j_q         <= j_d;
      rd_valid_q  <= (state_q == wsd_pkg::ST_RUN);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lag_pend_q <= lag_pend_d;
    diff_q     <= diff_d;
    lag_out_q  <= lag_out_d;
  end

  // sample stores
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[rp_c] <= sample_i;
    end
    if (ref_we) begin
      ref_mem[ref_wa] <= sample_i;
    end
    ring_rd_q <= ring_mem[rd_ptr_q];
    ref_rd_q  <= ref_mem[j_q];
  end

  assign acc_ctrl.clear      = acc_clear;
  assign acc_ctrl.pair_valid = rd_valid_q;

  wsd_sq_acc #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_sq_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .win_i   (ring_rd_q),
    .ref_i   (ref_rd_q),
    .shift_i (sample_bits_q),
    .stat_o  (acc_stat)
  );

  assign out_valid_o  = out_valid_q;
  assign difference_o = diff_q;
  assign lag_o        = lag_out_q;

  a_read_follows_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> $past(state_q == wsd_pkg::ST_RUN))
    else $error("read data marked valid outside a read sweep");

  a_fire_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (!rd_valid_q && !acc_stat.busy))
    else $error("transfer accepted with products still in flight");

  a_run_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wsd_pkg::ST_RUN) |-> (WCNT_W'(j_q) < w_eff))
    else $error("reference index beyond window");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= WIN_MAX)
    else $error("fill count beyond store depth");

  a_load_from_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == wsd_pkg::ST_WAIT))
    else $error("result loaded outside the drain state");

endmodule
